// File: design/mek_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mek_pkg
// Shared types and constants for the Morse element keyer: state and element
// encodings, the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mek_pkg;

   // Field widths
   localparam int CODE_W = 8;
   localparam int WPM_W  = 6;
   localparam int SEC_W  = 8;
   localparam int TICK_W = 5;
   localparam int DUR_W  = 10;

   // Timing constants
   localparam logic [DUR_W-1:0]  MS_PER_SEC     = 10'd1000;
   localparam logic [DUR_W-1:0]  DUR_MAX        = 10'd1000;
   localparam logic [CODE_W-1:0] LONG_DAH_ABOVE = 8'd128;
   localparam logic [TICK_W-1:0] GUARD_TICKS    = 5'd12;

   // Restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = DUR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // Element unit counts
   localparam logic [WPM_W-1:0] UNITS_DIT   = 6'd1;
   localparam logic [WPM_W-1:0] UNITS_DAH   = 6'd3;
   localparam logic [WPM_W-1:0] UNITS_GAP   = 6'd1;
   localparam logic [WPM_W-1:0] UNITS_FINAL = 6'd2;
   localparam logic [WPM_W-1:0] UNITS_WORD  = 6'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WORD,
      ST_KEY,
      ST_GAP,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      EL_WORD,
      EL_KEY,
      EL_GAP,
      EL_FINAL
   } elem_type;

   // Controller to datapath
   typedef struct packed {
      logic     load;
      logic     div_step;
      logic     emit;
      elem_type elem;
      logic     shift;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic guard_ok;
      logic div_done;
      logic code_zero;
      logic code_more;
      logic next_more;
      logic code_bit0;
      logic long_mode;
      logic rsp_free;
   } status_type;

endpackage

// File: design/morse_element_keyer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_element_keyer_core
// Turns one Morse character byte into its run of key-down / key-up elements
// with durations of (1000/wpm)*units ms, subject to a keying time guard.
//
//   channel  | direction | transaction carries
//   ---------+-----------+----------------------------------------------------
//   req_     | in        | char_code, speed_wpm, seconds_now, tick_left, key_limit
//   rsp_     | out       | key_on, duration_ms, last (up to 15 per character)
//
// A character is accepted, runs through the bit-serial divider, then issues its
// elements in order; a zero bit in long-dah mode issues no key element.
// A character failing the guard is taken and produces nothing.
// Reset clears the controller and the result valid; no sweep is needed.
// A stalled rsp_ holds the element sequencer; req_ready is high only between
// characters.
// ----------------------------------------------------------------------------
module morse_element_keyer_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mek_pkg::CODE_W-1:0]  req_char_code,
   input  logic [mek_pkg::WPM_W-1:0]   req_speed_wpm,
   input  logic [mek_pkg::SEC_W-1:0]   req_seconds_now,
   input  logic [mek_pkg::TICK_W-1:0]  req_tick_left,
   input  logic [mek_pkg::SEC_W-1:0]   req_key_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_key_on,
   output logic [mek_pkg::DUR_W-1:0]   rsp_duration_ms,
   output logic                        rsp_last
);
   import mek_pkg::*;

   cmd_type    cmd;
   status_type status;

   mek_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mek_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .req_speed_wpm   (req_speed_wpm),
      .req_seconds_now (req_seconds_now),
      .req_tick_left   (req_tick_left),
      .req_key_limit   (req_key_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_on      (rsp_key_on),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// File: design/mek_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mek_ctrl
// Controller: sequences divide, optional word space, key/gap pairs per code
// bit and the closing character gap.
// ----------------------------------------------------------------------------
module mek_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mek_pkg::status_type status,
   output mek_pkg::cmd_type    cmd
);
   import mek_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.guard_ok) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (status.code_zero) begin
                  state_in = ST_WORD;
               end else if (status.code_more) begin
                  state_in = ST_KEY;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_WORD: begin
            if (status.rsp_free) begin
               state_in = ST_FINAL;
            end
         end
         ST_KEY: begin
            // long-dah zero bits send no key element
            if ((status.long_mode && !status.code_bit0) || status.rsp_free) begin
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            if (status.rsp_free) begin
               state_in = status.next_more ? ST_KEY : ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit     = 1'b0;
      cmd.elem     = EL_GAP;
      cmd.shift    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_WORD: begin
            cmd.elem = EL_WORD;
            cmd.emit = status.rsp_free;
         end
         ST_KEY: begin
            cmd.elem = EL_KEY;
            cmd.emit = status.rsp_free && !(status.long_mode && !status.code_bit0);
         end
         ST_GAP: begin
            cmd.elem  = EL_GAP;
            cmd.emit  = status.rsp_free;
            cmd.shift = status.rsp_free;
         end
         ST_FINAL: begin
            cmd.elem = EL_FINAL;
            cmd.emit = status.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Checks
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("element emitted over an untaken result");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_done) |=> state_ff != ST_DIVIDE)
      else $error("divider did not hand over after last step");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.elem == EL_FINAL) |=> state_ff == ST_IDLE)
      else $error("character gap not followed by idle");

endmodule

// File: design/mek_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mek_dpath
// Datapath: guard compare, bit-serial 1000/wpm divider, code shifter,
// duration multiply with saturation and the result output register.
// ----------------------------------------------------------------------------
module mek_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mek_pkg::CODE_W-1:0]          req_char_code,
   input  logic [mek_pkg::WPM_W-1:0]           req_speed_wpm,
   input  logic [mek_pkg::SEC_W-1:0]           req_seconds_now,
   input  logic [mek_pkg::TICK_W-1:0]          req_tick_left,
   input  logic [mek_pkg::SEC_W-1:0]           req_key_limit,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_key_on,
   output logic [mek_pkg::DUR_W-1:0]           rsp_duration_ms,
   output logic                                rsp_last,
   input  mek_pkg::cmd_type                    cmd,
   output mek_pkg::status_type                 status
);
   import mek_pkg::*;

   logic [CODE_W-1:0]    code_ff;
   logic                 long_ff;
   logic [WPM_W-1:0]     wpm_ff;
   logic [WPM_W-1:0]     wpm_adj;
   logic [WPM_W-1:0]     rem_ff, rem_in;
   logic [DUR_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [WPM_W:0]       trial;
   logic [WPM_W:0]       diff;
   logic                 ge;
   logic [WPM_W-1:0]     units;
   logic [15:0]          prod;
   logic [DUR_W-1:0]     dur;
   logic                 rsp_valid_ff;
   logic                 key_ff;
   logic [DUR_W-1:0]     dur_ff;
   logic                 last_ff;

   // Speed zero behaves as one
   assign wpm_adj = (req_speed_wpm == '0) ? WPM_W'(1) : req_speed_wpm;

   // Divider step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[DUR_W-1]};
      diff   = trial - {1'b0, wpm_ff};
      ge     = (trial >= {1'b0, wpm_ff});
      rem_in = ge ? diff[WPM_W-1:0] : trial[WPM_W-1:0];
      quo_in = {quo_ff[DUR_W-2:0], ge};
   end

   // Operand and divider registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= req_char_code;
         long_ff <= (req_char_code > LONG_DAH_ABOVE);
         wpm_ff  <= wpm_adj;
         rem_ff  <= '0;
         quo_ff  <= MS_PER_SEC;
         cnt_ff  <= '0;
      end else begin
         if (cmd.div_step) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         end
         if (cmd.shift) begin
            code_ff <= code_ff >> 1;
         end
      end
   end

   // Element length in units
   always_comb begin
      case (cmd.elem)
         EL_WORD:  units = UNITS_WORD;
         EL_KEY:   units = long_ff ? wpm_ff : (code_ff[0] ? UNITS_DAH : UNITS_DIT);
         EL_GAP:   units = UNITS_GAP;
         EL_FINAL: units = UNITS_FINAL;
         default:  units = UNITS_GAP;
      endcase
   end

   // Duration with saturation; quo_ff holds the unit length in ms
   always_comb begin
      prod = 16'(quo_ff) * 16'(units);
      dur  = (prod > 16'(DUR_MAX)) ? DUR_MAX : prod[DUR_W-1:0];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         key_ff  <= (cmd.elem == EL_KEY);
         dur_ff  <= dur;
         last_ff <= (cmd.elem == EL_FINAL);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_on      = key_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_last        = last_ff;

   // Status to controller
   always_comb begin
      status.guard_ok  = (req_seconds_now < req_key_limit) ||
                         ((req_seconds_now == req_key_limit) &&
                          (req_tick_left >= GUARD_TICKS));
      status.div_done  = (cnt_ff == DIV_LAST);
      status.code_zero = (code_ff == '0);
      status.code_more = |code_ff[CODE_W-1:1];
      status.next_more = |code_ff[CODE_W-1:2];
      status.code_bit0 = code_ff[0];
      status.long_mode = long_ff;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Checks
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted element not presented");

   a_last_space: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> !key_ff)
      else $error("final element keyed down");

   a_dur_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dur_ff <= DUR_MAX))
      else $error("duration above cap");

endmodule
